[rtl/core/ljpf_pkg.sv]
`timescale 1ns / 1ps
package ljpf_pkg;

	localparam int unsigned POS_W = 24;
	localparam int unsigned D_W   = 25;
	localparam int unsigned R2_W  = 32;
	localparam int unsigned S_W   = 40;
	localparam int unsigned MAG_W = 61;
	localparam int unsigned OUT_W = 56;
	localparam int unsigned CFG_W = 32;
	localparam int unsigned IDX_W = 3;

	// register indexes
	localparam logic [IDX_W-1:0] REG_BOX_LENGTH  = 3'd0;
	localparam logic [IDX_W-1:0] REG_CUTOFF_SQ   = 3'd1;
	localparam logic [IDX_W-1:0] REG_SIGMA_SQ    = 3'd2;
	localparam logic [IDX_W-1:0] REG_EPSILON     = 3'd3;
	localparam logic [IDX_W-1:0] REG_MIN_DIST_SQ = 3'd4;

	localparam logic [63:0]      CAP_W64  = 64'h1 << 60;
	localparam logic [MAG_W-1:0] CAP      = CAP_W64[MAG_W-1:0];
	localparam logic [MAG_W-1:0] LIM_X2   = CAP >> 1;
	localparam logic [MAG_W-1:0] LIM_X4   = CAP >> 2;
	localparam logic [63:0]      LIM24_64 = CAP_W64 / 64'd24;
	localparam logic [MAG_W-1:0] LIM_X24  = LIM24_64[MAG_W-1:0];
	localparam logic [MAG_W-1:0] SMAX     = (61'h1 << 55) - 61'h1;
	localparam logic [MAG_W-1:0] SMIN_MAG = 61'h1 << 55;

	// pipeline latencies
	localparam int unsigned FRONT_LAT = 4;
	localparam int unsigned DA_STEPS  = S_W;
	localparam int unsigned DB_STEPS  = 60;
	localparam int unsigned MUL_LAT   = 2;
	localparam int unsigned LATENCY   = FRONT_LAT + DA_STEPS + 3 * MUL_LAT + 1 + MUL_LAT + 1
		+ 1 + DB_STEPS + MUL_LAT + 1;

	typedef struct packed {
		logic                      inr;
		logic [R2_W-1:0]           r2;
		logic [2:0][D_W-1:0]       d;
		logic [S_W-1:0]            s;
		logic [MAG_W-1:0]          sr6;
		logic                      eneg;
		logic                      fneg;
		logic [OUT_W-1:0]          energy;
	} side_t;

	function automatic logic [MAG_W-1:0] scale_x2(input logic [MAG_W-1:0] x);
		return (x > LIM_X2) ? CAP : {x[MAG_W-2:0], 1'b0};
	endfunction

	function automatic logic [MAG_W-1:0] scale_x4(input logic [MAG_W-1:0] x);
		return (x > LIM_X4) ? CAP : {x[MAG_W-3:0], 2'b00};
	endfunction

	function automatic logic [MAG_W-1:0] scale_x24(input logic [MAG_W-1:0] x);
		logic [MAG_W+4:0] p;
		p = {x, 5'b0} - {2'b0, x, 3'b0};
		return (x > LIM_X24) ? CAP : p[MAG_W-1:0];
	endfunction

	function automatic logic [OUT_W-1:0] sat56(input logic neg, input logic [MAG_W-1:0] mag);
		logic [MAG_W-1:0] m;
		logic [MAG_W-1:0] n;
		m = (mag > SMIN_MAG) ? SMIN_MAG : mag;
		n = '0 - m;
		if (!neg) begin
			return (mag > SMAX) ? SMAX[OUT_W-1:0] : mag[OUT_W-1:0];
		end
		return n[OUT_W-1:0];
	endfunction

	function automatic logic [D_W-1:0] abs_d(input logic [D_W-1:0] d);
		return d[D_W-1] ? ('0 - d) : d;
	endfunction

endpackage

[rtl/core/lennard_jones_pair_force.sv]
`timescale 1ns / 1ps
// throughput: one request per cycle; busy stays low, the pipeline never stalls
// the latency is set by the bit-per-stage dividers (40 and 60 stages) and split multipliers
// reset clears every stage valid bit and loads the register defaults
// results appear for one cycle on done; the receiver cannot stall
module lennard_jones_pair_force (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [ljpf_pkg::POS_W-1:0]            pos_i_x,
	input  logic [ljpf_pkg::POS_W-1:0]            pos_i_y,
	input  logic [ljpf_pkg::POS_W-1:0]            pos_i_z,
	input  logic [ljpf_pkg::POS_W-1:0]            pos_j_x,
	input  logic [ljpf_pkg::POS_W-1:0]            pos_j_y,
	input  logic [ljpf_pkg::POS_W-1:0]            pos_j_z,
	input  logic                                  cfg_wr_en,
	input  logic [ljpf_pkg::IDX_W-1:0]            cfg_index,
	input  logic [ljpf_pkg::CFG_W-1:0]            cfg_wdata,
	output logic                                  done,
	output logic signed [ljpf_pkg::OUT_W-1:0]     force_x,
	output logic signed [ljpf_pkg::OUT_W-1:0]     force_y,
	output logic signed [ljpf_pkg::OUT_W-1:0]     force_z,
	output logic signed [ljpf_pkg::OUT_W-1:0]     pair_energy,
	output logic                                  in_range
);
	import ljpf_pkg::*;

	logic [23:0] box_q;
	logic [31:0] cutoff_q;
	logic [23:0] sigma_q;
	logic [23:0] eps_q;
	logic [31:0] min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q    <= 24'd655360;
			cutoff_q <= 32'd409600;
			sigma_q  <= 24'd65536;
			eps_q    <= 24'd65536;
			min_q    <= 32'd13107;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_BOX_LENGTH:  box_q    <= cfg_wdata[23:0];
				REG_CUTOFF_SQ:   cutoff_q <= cfg_wdata;
				REG_SIGMA_SQ:    sigma_q  <= cfg_wdata[23:0];
				REG_EPSILON:     eps_q    <= cfg_wdata[23:0];
				REG_MIN_DIST_SQ: min_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// front end: fold, square, sum, floor and range check
	logic [POS_W-1:0]          pi [3];
	logic [POS_W-1:0]          pj [3];
	logic [2:0][D_W-1:0]       d_fold;
	logic [2:0][D_W-1:0]       d_s1;
	logic [2:0][D_W-1:0]       d_s2;
	logic [2:0][D_W-1:0]       d_s3;
	logic [2*D_W-1:0]          sq_s2 [3];
	logic [35:0]               r2raw_s3;
	side_t                     side_s4;
	side_t                     side_nx4;
	logic                      v_s1, v_s2, v_s3, v_s4;
	logic [2*D_W+1:0]          sum;
	logic [35:0]               r2c;

	assign pi = '{pos_i_x, pos_i_y, pos_i_z};
	assign pj = '{pos_j_x, pos_j_y, pos_j_z};

	always_comb begin
		logic signed [25:0] diff;
		logic signed [26:0] two_d;
		logic signed [26:0] l27;
		logic signed [25:0] l26;
		logic signed [25:0] df;
		l27 = $signed({3'b0, box_q});
		l26 = $signed({2'b0, box_q});
		for (int k = 0; k < 3; k++) begin
			diff  = $signed({2'b0, pi[k]}) - $signed({2'b0, pj[k]});
			two_d = {diff, 1'b0};
			if (two_d > l27) df = diff - l26;
			else if (two_d < -l27) df = diff + l26;
			else df = diff;
			d_fold[k] = df[D_W-1:0];
		end
	end

	assign sum = (2*D_W+2)'(sq_s2[0]) + (2*D_W+2)'(sq_s2[1]) + (2*D_W+2)'(sq_s2[2]);
	assign r2c = (r2raw_s3 < {4'b0, min_q}) ? {4'b0, min_q} : r2raw_s3;

	always_comb begin
		side_nx4     = '0;
		side_nx4.d   = d_s3;
		side_nx4.r2  = r2c[R2_W-1:0];
		side_nx4.inr = (r2c != '0) && (r2c <= {4'b0, cutoff_q});
	end

	always_ff @(posedge clk) begin
		d_s1 <= d_fold;
		d_s2 <= d_s1;
		for (int k = 0; k < 3; k++) begin
			sq_s2[k] <= abs_d(d_s1[k]) * abs_d(d_s1[k]);
		end
		d_s3     <= d_s2;
		r2raw_s3 <= sum[2*D_W+1:16];
		side_s4  <= side_nx4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// divider a: s = (sigma_sq << 16) / r2, one quotient bit a stage
	logic [R2_W-1:0]     da_rem_s  [DA_STEPS];
	logic [S_W-1:0]      da_word_s [DA_STEPS];
	side_t               da_side_s [DA_STEPS];
	logic [DA_STEPS-1:0] da_v_s;

	for (genvar i = 0; i < DA_STEPS; i++) begin : g_div_a
		logic [R2_W-1:0] rem_in;
		logic [S_W-1:0]  word_in;
		side_t           side_in;
		logic            v_in;
		logic [R2_W:0]   t;
		logic            take;
		if (i == 0) begin : g_first
			assign rem_in  = '0;
			assign word_in = {sigma_q, 16'h0};
			assign side_in = side_s4;
			assign v_in    = v_s4;
		end else begin : g_next
			assign rem_in  = da_rem_s[i-1];
			assign word_in = da_word_s[i-1];
			assign side_in = da_side_s[i-1];
			assign v_in    = da_v_s[i-1];
		end
		assign t    = {rem_in, word_in[S_W-1]};
		assign take = t >= {1'b0, side_in.r2};
		always_ff @(posedge clk) begin
			da_rem_s[i]  <= take ? R2_W'(t - {1'b0, side_in.r2}) : t[R2_W-1:0];
			da_word_s[i] <= {word_in[S_W-2:0], take};
			da_side_s[i] <= side_in;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) da_v_s[i] <= 1'b0;
			else da_v_s[i] <= v_in;
		end
	end

	// powers of sigma^2/r^2
	side_t            m1_side_in;
	side_t            m1_side, m2_side, m3_side, m3_side_in;
	logic             m1_v, m2_v, m3_v;
	logic [MAG_W-1:0] s_ext, s2, sr6, sr12;

	assign s_ext = MAG_W'(da_word_s[DA_STEPS-1]);
	always_comb begin
		m1_side_in   = da_side_s[DA_STEPS-1];
		m1_side_in.s = da_word_s[DA_STEPS-1];
	end

	ljpf_mulq u_mul_s2 (
		.clk, .arst_n, .vin(da_v_s[DA_STEPS-1]), .a(s_ext), .b(s_ext),
		.side_in(m1_side_in), .vout(m1_v), .p(s2), .side_out(m1_side)
	);

	ljpf_mulq u_mul_sr6 (
		.clk, .arst_n, .vin(m1_v), .a(s2), .b(MAG_W'(m1_side.s)),
		.side_in(m1_side), .vout(m2_v), .p(sr6), .side_out(m2_side)
	);

	always_comb begin
		m3_side_in     = m2_side;
		m3_side_in.sr6 = sr6;
	end

	ljpf_mulq u_mul_sr12 (
		.clk, .arst_n, .vin(m2_v), .a(sr6), .b(sr6),
		.side_in(m3_side_in), .vout(m3_v), .p(sr12), .side_out(m3_side)
	);

	// energy and force differences
	logic [MAG_W-1:0] emag_e1, fmag_e1;
	side_t            side_e1;
	side_t            side_nx_e1;
	logic             v_e1;
	logic [MAG_W-1:0] sr12x2;

	assign sr12x2 = scale_x2(sr12);

	always_comb begin
		side_nx_e1      = m3_side;
		side_nx_e1.eneg = sr12 < m3_side.sr6;
		side_nx_e1.fneg = sr12x2 < m3_side.sr6;
	end

	always_ff @(posedge clk) begin
		side_e1      <= side_nx_e1;
		emag_e1      <= (sr12 < m3_side.sr6) ? m3_side.sr6 - sr12 : sr12 - m3_side.sr6;
		fmag_e1      <= (sr12x2 < m3_side.sr6) ? m3_side.sr6 - sr12x2 : sr12x2 - m3_side.sr6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_e1 <= 1'b0;
		else v_e1 <= m3_v;
	end

	side_t            m4_side;
	logic             m4_v;
	logic [MAG_W-1:0] pe, pf;

	ljpf_mulq u_mul_eps_e (
		.clk, .arst_n, .vin(v_e1), .a(MAG_W'(eps_q)), .b(emag_e1),
		.side_in(side_e1), .vout(m4_v), .p(pe), .side_out(m4_side)
	);

	ljpf_mulq u_mul_eps_f (
		.clk, .arst_n, .vin(v_e1), .a(MAG_W'(eps_q)), .b(fmag_e1),
		.side_in(side_e1), .vout(), .p(pf), .side_out()
	);

	logic [MAG_W-1:0] fm24_e2;
	side_t            side_e2;
	side_t            side_nx_e2;
	logic             v_e2;

	always_comb begin
		side_nx_e2        = m4_side;
		side_nx_e2.energy = sat56(m4_side.eneg, scale_x4(pe));
	end

	always_ff @(posedge clk) begin
		side_e2        <= side_nx_e2;
		fm24_e2        <= scale_x24(pf);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_e2 <= 1'b0;
		else v_e2 <= m4_v;
	end

	// divider b: fr = (fm24 << 16) / r2 with fm24 = 24 * eps * fmag, capped once the quotient reaches 2^60
	logic [R2_W-1:0]     db0_rem_s;
	logic [DB_STEPS-1:0] db0_word_s;
	logic                db0_ovf_s;
	side_t               db0_side_s;
	logic                db0_v_s;
	logic [R2_W-1:0]     db_rem_s  [DB_STEPS];
	logic [DB_STEPS-1:0] db_word_s [DB_STEPS];
	logic                db_ovf_s  [DB_STEPS];
	side_t               db_side_s [DB_STEPS];
	logic [DB_STEPS-1:0] db_v_s;

	always_ff @(posedge clk) begin
		db0_rem_s  <= R2_W'(fm24_e2[MAG_W-1:44]);
		db0_word_s <= {fm24_e2[43:0], 16'h0};
		db0_ovf_s  <= {15'b0, fm24_e2[MAG_W-1:44]} >= side_e2.r2;
		db0_side_s <= side_e2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) db0_v_s <= 1'b0;
		else db0_v_s <= v_e2;
	end

	for (genvar i = 0; i < DB_STEPS; i++) begin : g_div_b
		logic [R2_W-1:0]     rem_in;
		logic [DB_STEPS-1:0] word_in;
		logic                ovf_in;
		side_t               side_in;
		logic                v_in;
		logic [R2_W:0]       t;
		logic                take;
		if (i == 0) begin : g_first
			assign rem_in  = db0_rem_s;
			assign word_in = db0_word_s;
			assign ovf_in  = db0_ovf_s;
			assign side_in = db0_side_s;
			assign v_in    = db0_v_s;
		end else begin : g_next
			assign rem_in  = db_rem_s[i-1];
			assign word_in = db_word_s[i-1];
			assign ovf_in  = db_ovf_s[i-1];
			assign side_in = db_side_s[i-1];
			assign v_in    = db_v_s[i-1];
		end
		assign t    = {rem_in, word_in[DB_STEPS-1]};
		assign take = t >= {1'b0, side_in.r2};
		always_ff @(posedge clk) begin
			db_rem_s[i]  <= take ? R2_W'(t - {1'b0, side_in.r2}) : t[R2_W-1:0];
			db_word_s[i] <= {word_in[DB_STEPS-2:0], take};
			db_ovf_s[i]  <= ovf_in;
			db_side_s[i] <= side_in;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) db_v_s[i] <= 1'b0;
			else db_v_s[i] <= v_in;
		end
	end

	// force components
	logic [MAG_W-1:0] fr;
	side_t            dbl_side;
	side_t            m5_side;
	logic             m5_v;
	logic [MAG_W-1:0] pfx, pfy, pfz;

	assign dbl_side = db_side_s[DB_STEPS-1];
	assign fr = db_ovf_s[DB_STEPS-1] ? CAP : MAG_W'(db_word_s[DB_STEPS-1]);

	ljpf_mulq u_mul_fx (
		.clk, .arst_n, .vin(db_v_s[DB_STEPS-1]), .a(fr), .b(MAG_W'(abs_d(dbl_side.d[0]))),
		.side_in(dbl_side), .vout(m5_v), .p(pfx), .side_out(m5_side)
	);

	ljpf_mulq u_mul_fy (
		.clk, .arst_n, .vin(db_v_s[DB_STEPS-1]), .a(fr), .b(MAG_W'(abs_d(dbl_side.d[1]))),
		.side_in(dbl_side), .vout(), .p(pfy), .side_out()
	);

	ljpf_mulq u_mul_fz (
		.clk, .arst_n, .vin(db_v_s[DB_STEPS-1]), .a(fr), .b(MAG_W'(abs_d(dbl_side.d[2]))),
		.side_in(dbl_side), .vout(), .p(pfz), .side_out()
	);

	logic neg_x, neg_y, neg_z;
	// a zero difference never takes the negative sign
	assign neg_x = (m5_side.fneg != m5_side.d[0][D_W-1]) && (m5_side.d[0] != '0);
	assign neg_y = (m5_side.fneg != m5_side.d[1][D_W-1]) && (m5_side.d[1] != '0);
	assign neg_z = (m5_side.fneg != m5_side.d[2][D_W-1]) && (m5_side.d[2] != '0);

	always_ff @(posedge clk) begin
		force_x     <= m5_side.inr ? $signed(sat56(neg_x, pfx)) : '0;
		force_y     <= m5_side.inr ? $signed(sat56(neg_y, pfy)) : '0;
		force_z     <= m5_side.inr ? $signed(sat56(neg_z, pfz)) : '0;
		pair_energy <= m5_side.inr ? $signed(m5_side.energy) : '0;
		in_range    <= m5_side.inr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= m5_v;
	end

	a_done_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result strobe without a matching request");

	a_out_of_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !in_range |-> force_x == '0 && force_y == '0 && force_z == '0
			&& pair_energy == '0)
		else $error("out-of-range pair gave nonzero result");

	a_divider_valid_flow: assert property (@(posedge clk) disable iff (!arst_n)
		da_v_s[DA_STEPS-1] |-> ##(3 * MUL_LAT + MUL_LAT + 3 + DB_STEPS) db_v_s[DB_STEPS-1])
		else $error("valid lost between the two dividers");

endmodule

[rtl/core/ljpf_mulq.sv]
`timescale 1ns / 1ps
module ljpf_mulq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          vin,
	input  logic [ljpf_pkg::MAG_W-1:0]    a,
	input  logic [ljpf_pkg::MAG_W-1:0]    b,
	input  ljpf_pkg::side_t               side_in,
	output logic                          vout,
	output logic [ljpf_pkg::MAG_W-1:0]    p,
	output ljpf_pkg::side_t               side_out
);
	import ljpf_pkg::*;

	localparam int unsigned LO_W = 31;
	localparam int unsigned HI_W = MAG_W - LO_W;
	localparam int unsigned P_W  = 2 * MAG_W;

	logic [2*LO_W-1:0]      ll_s1;
	logic [LO_W+HI_W-1:0]   lh_s1;
	logic [LO_W+HI_W-1:0]   hl_s1;
	logic [2*HI_W-1:0]      hh_s1;
	side_t                  side_s1;
	logic                   v_s1;

	logic [P_W-1:0]         full;
	logic [P_W-17:0]        shifted;

	// four partial products, summed in the next stage
	always_ff @(posedge clk) begin
		ll_s1   <= a[LO_W-1:0] * b[LO_W-1:0];
		lh_s1   <= a[LO_W-1:0] * b[MAG_W-1:LO_W];
		hl_s1   <= a[MAG_W-1:LO_W] * b[LO_W-1:0];
		hh_s1   <= a[MAG_W-1:LO_W] * b[MAG_W-1:LO_W];
		side_s1 <= side_in;
	end

	assign full = P_W'(ll_s1) + (P_W'(lh_s1) << LO_W) + (P_W'(hl_s1) << LO_W)
		+ (P_W'(hh_s1) << (2 * LO_W));
	assign shifted = full[P_W-1:16];

	always_ff @(posedge clk) begin
		p        <= (shifted > (P_W-16)'(CAP)) ? CAP : shifted[MAG_W-1:0];
		side_out <= side_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			vout <= 1'b0;
		end else begin
			v_s1 <= vin;
			vout <= v_s1;
		end
	end

endmodule
